[src/wavhp_pkg.sv]
// Shared types and constants for the WAV header parser.
// Used by the front, queue, back and top-level files; no dependencies.
package wavhp_pkg;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_EOF     = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_SHORT_FMT = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_NO_DATA   = 3'd5;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666d_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;
  localparam logic [15:0] PCM_TAG = 16'd1;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] POS_MAX     = 32'hffff_ffff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_EOF,
    CMD_RESTART
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] pcm_start;
    logic [31:0] pcm_bytes;
  } result_t;

endpackage

[src/wavhp_front.sv]
// Front end of the WAV header parser: accepts input words and classifies them.
// Depends on wavhp_pkg; feeds wavhp_queue.
module wavhp_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         data_byte_i,
  input  logic               full_i,
  output logic               push_o,
  output wavhp_pkg::item_t   item_o
);

  logic known;

  always_comb begin
    known       = 1'b1;
    item_o.data = data_byte_i;
    item_o.cmd  = wavhp_pkg::CMD_BYTE;
    unique case (action_i)
      wavhp_pkg::ACT_BYTE:    item_o.cmd = wavhp_pkg::CMD_BYTE;
      wavhp_pkg::ACT_EOF:     item_o.cmd = wavhp_pkg::CMD_EOF;
      wavhp_pkg::ACT_RESTART: item_o.cmd = wavhp_pkg::CMD_RESTART;
      default:                known      = 1'b0;
    endcase
  end

  // drop unknown actions at the door
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && known;

endmodule

[src/wavhp_queue.sv]
// Short queue between front and back of the WAV header parser.
// Depends on wavhp_pkg.
module wavhp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wavhp_pkg::item_t   item_i,
  input  logic               pop_i,
  output wavhp_pkg::item_t   item_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int AW = wavhp_pkg::QUEUE_AW;

  wavhp_pkg::item_t mem_q [wavhp_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;

  assign full_o  = (count_q == (AW+1)'(wavhp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule

[src/wavhp_back.sv]
// Back end of the WAV header parser: chunk walker and result register.
// Depends on wavhp_pkg; drains wavhp_queue.
module wavhp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  wavhp_pkg::item_t    item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wavhp_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [63:0]        hdr_q, hdr_d;
  logic [32:0]        skip_q, skip_d;
  logic               fmt_seen_q, fmt_seen_d;
  logic [15:0]        tag_q, tag_d;
  logic [31:0]        len_q, len_d;
  logic [15:0]        chan_q, chan_d;
  logic [31:0]        rate_q, rate_d;
  logic [15:0]        bits_q, bits_d;
  logic [31:0]        pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  wavhp_pkg::result_t out_q, out_d;

  logic [63:0] shift_in;
  logic [31:0] pos_inc;
  logic [31:0] size;
  logic [32:0] chunk_skip;
  logic [32:0] fmt_skip;
  logic [32:0] skip_dec;
  logic [7:0]  b;

  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  assign b          = item_i.data;
  assign shift_in   = {hdr_q[55:0], b};
  assign pos_inc    = (pos_q == wavhp_pkg::POS_MAX) ? pos_q : pos_q + 32'd1;
  assign size       = {shift_in[7:0], shift_in[15:8], shift_in[23:16], shift_in[31:24]};
  assign chunk_skip = {1'b0, size} + {32'd0, size[0]};
  assign fmt_skip   = {1'b0, len_q - wavhp_pkg::FMT_MIN_LEN} + {32'd0, len_q[0]};
  assign skip_dec   = (skip_q != '0) ? skip_q - 33'd1 : skip_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    hdr_d       = hdr_q;
    skip_d      = skip_q;
    fmt_seen_d  = fmt_seen_q;
    tag_d       = tag_q;
    len_d       = len_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    bits_d      = bits_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (pop_o) begin
      unique case (item_i.cmd)
        wavhp_pkg::CMD_RESTART: begin
          phase_d    = PH_HEADER;
          cnt_d      = '0;
          hdr_d      = '0;
          skip_d     = '0;
          fmt_seen_d = 1'b0;
          tag_d      = '0;
          len_d      = '0;
          chan_d     = '0;
          rate_d     = '0;
          bits_d     = '0;
          pos_d      = '0;
        end
        wavhp_pkg::CMD_EOF: begin
          if (phase_q != PH_DONE) begin
            out_valid_d           = 1'b1;
            out_d.channels        = chan_q;
            out_d.sample_rate     = rate_q;
            out_d.bits_per_sample = bits_q;
            out_d.pcm_start       = '0;
            out_d.pcm_bytes       = '0;
            unique case (phase_q)
              PH_HEADER: out_d.status = wavhp_pkg::ST_NOT_RIFF;
              PH_FMT:    out_d.status = wavhp_pkg::ST_TRUNC;
              default:   out_d.status = wavhp_pkg::ST_NO_DATA;
            endcase
            phase_d = PH_DONE;
          end
        end
        default: begin
          if (phase_q != PH_DONE) begin
            pos_d                 = pos_inc;
            cnt_d                 = cnt_q + 4'd1;
            out_d.channels        = chan_q;
            out_d.sample_rate     = rate_q;
            out_d.bits_per_sample = bits_q;
            out_d.pcm_start       = '0;
            out_d.pcm_bytes       = '0;
            out_d.status          = wavhp_pkg::ST_OK;
            unique case (phase_q)
              PH_HEADER: begin
                if (cnt_q < 4'd4 || cnt_q >= 4'd8) begin
                  hdr_d = shift_in;
                end
                if (cnt_q == 4'd11) begin
                  if (shift_in != {wavhp_pkg::ID_RIFF, wavhp_pkg::ID_WAVE}) begin
                    out_valid_d  = 1'b1;
                    out_d.status = wavhp_pkg::ST_NOT_RIFF;
                    phase_d      = PH_DONE;
                  end else begin
                    phase_d = PH_CHUNK;
                    cnt_d   = '0;
                    hdr_d   = '0;
                  end
                end
              end
              PH_CHUNK: begin
                hdr_d = shift_in;
                if (cnt_q == 4'd7) begin
                  if (shift_in[63:32] == wavhp_pkg::ID_FMT) begin
                    if (size < wavhp_pkg::FMT_MIN_LEN) begin
                      out_valid_d  = 1'b1;
                      out_d.status = wavhp_pkg::ST_SHORT_FMT;
                      phase_d      = PH_DONE;
                    end else begin
                      len_d   = size;
                      phase_d = PH_FMT;
                      cnt_d   = '0;
                      hdr_d   = '0;
                    end
                  end else if (shift_in[63:32] == wavhp_pkg::ID_DATA && fmt_seen_q) begin
                    out_valid_d     = 1'b1;
                    out_d.status    = wavhp_pkg::ST_OK;
                    out_d.pcm_start = pos_inc;
                    out_d.pcm_bytes = size;
                    phase_d         = PH_DONE;
                  end else if (chunk_skip == '0) begin
                    phase_d = PH_CHUNK;
                    cnt_d   = '0;
                    hdr_d   = '0;
                  end else begin
                    skip_d  = chunk_skip;
                    phase_d = PH_SKIP;
                  end
                end
              end
              PH_FMT: begin
                if (cnt_q == 4'd0) begin
                  tag_d = {8'd0, b};
                end else if (cnt_q == 4'd1) begin
                  tag_d = {b, tag_q[7:0]};
                end else if (cnt_q <= 4'd7 || cnt_q >= 4'd14) begin
                  hdr_d = shift_in;
                end
                if (cnt_q == 4'd15) begin
                  if (tag_q != wavhp_pkg::PCM_TAG) begin
                    out_valid_d  = 1'b1;
                    out_d.status = wavhp_pkg::ST_NOT_PCM;
                    phase_d      = PH_DONE;
                  end else begin
                    chan_d     = {shift_in[55:48], shift_in[63:56]};
                    rate_d     = {shift_in[23:16], shift_in[31:24],
                                  shift_in[39:32], shift_in[47:40]};
                    bits_d     = {shift_in[7:0], shift_in[15:8]};
                    fmt_seen_d = 1'b1;
                    if (fmt_skip == '0) begin
                      phase_d = PH_CHUNK;
                      cnt_d   = '0;
                      hdr_d   = '0;
                    end else begin
                      skip_d  = fmt_skip;
                      phase_d = PH_SKIP;
                    end
                  end
                end
              end
              PH_SKIP: begin
                cnt_d  = cnt_q;
                skip_d = skip_dec;
                if (skip_dec == '0) begin
                  phase_d = PH_CHUNK;
                  cnt_d   = '0;
                  hdr_d   = '0;
                end
              end
              default: begin
                cnt_d = cnt_q;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      hdr_q       <= '0;
      skip_q      <= '0;
      fmt_seen_q  <= 1'b0;
      tag_q       <= '0;
      len_q       <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      hdr_q       <= hdr_d;
      skip_q      <= skip_d;
      fmt_seen_q  <= fmt_seen_d;
      tag_q       <= tag_d;
      len_q       <= len_d;
      chan_q      <= chan_d;
      rate_q      <= rate_d;
      bits_q      <= bits_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

[src/wav_header_parser_unit.sv]
// WAV header parser, top level: RIFF/WAVE PCM header walker fed one byte per word.
// Usage:
//   Input channel (in_valid_i / in_stall_o): action_i 0 carries a file byte in
//   data_byte_i, 1 marks end of file, 2 restarts the parse; code 3 is dropped.
//   Output channel (out_valid_o / out_stall_i): at most one result word per parse
//   with status, the format fields of the last good fmt chunk, and for status ok the
//   start position and byte length of the sample data.
// Timing:
//   An accepted word is written into the queue, then parsed from the queue head;
//   its result, if any, is held in the registered result stage until taken.
//   Throughput is one word per cycle when no result is stalled: a four-entry
//   queue sits between the front classifier and the parser, and the registered
//   result stage is refilled in the cycle its word is taken; the parser takes one
//   queued word per cycle. While out_stall_i holds a result, the parser halts and
//   the queue fills; in_stall_o rises when the queue is full.
// Reset:
//   rst_ni clears the queue, the parser state and the result stage at once; the
//   block, with its queue empty, holds in_stall_o low and accepts words.
// Depends on wavhp_pkg, wavhp_front, wavhp_queue and wavhp_back.
module wav_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] channels_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] pcm_start_o,
  output logic [31:0] pcm_bytes_o
);

  logic               q_push, q_pop, q_full, q_empty;
  wavhp_pkg::item_t   push_item, head_item;
  wavhp_pkg::result_t result;

  wavhp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .item_o      (push_item)
  );

  wavhp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wavhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .item_i      (head_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o          = result.status;
  assign channels_o        = result.channels;
  assign sample_rate_o     = result.sample_rate;
  assign bits_per_sample_o = result.bits_per_sample;
  assign pcm_start_o       = result.pcm_start;
  assign pcm_bytes_o       = result.pcm_bytes;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !q_pop) else $error("parser advanced under stall");

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == wavhp_pkg::ST_OK) |-> (pcm_start_o >= 32'd44))
    else $error("ok result with impossible sample start");
`endif

endmodule

[dv/wav_header_parser_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for wav_header_parser_unit: random RIFF/WAVE files, byte by byte,
// checked against a parse predictor in the bench. Depends on wavhp_pkg and the RTL.
module wav_header_parser_unit_tb;
  import wavhp_pkg::*;

  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam logic [31:0] ID_LIST    = 32'h4c49_5354;
  localparam int          MIN_WORDS  = 1900;
  localparam int          MIN_FILES  = 40;
  localparam int          HOLD_LEN   = 300;

  typedef enum logic [2:0] {
    WALK_HEADER,
    WALK_CHUNK,
    WALK_FMT,
    WALK_SKIP,
    WALK_DONE
  } walk_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] channels_o;
  logic [31:0] sample_rate_o;
  logic [15:0] bits_per_sample_o;
  logic [31:0] pcm_start_o;
  logic [31:0] pcm_bytes_o;

  wav_header_parser_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .channels_o        (channels_o),
    .sample_rate_o     (sample_rate_o),
    .bits_per_sample_o (bits_per_sample_o),
    .pcm_start_o       (pcm_start_o),
    .pcm_bytes_o       (pcm_bytes_o)
  );

  word_t       file_words_q[$];
  logic [7:0]  file_bytes[$];
  result_t     header_reports_q[$];
  int          stim_words;
  int          mismatch_cnt;

  // parser predictor state
  walk_e       walk;
  logic [3:0]  fld_cnt;
  logic [63:0] shreg;
  logic [32:0] skip_left;
  logic        fmt_seen;
  logic [15:0] fmt_tag;
  logic [31:0] fmt_len;
  logic [15:0] ch_cnt;
  logic [31:0] rate;
  logic [15:0] bits;
  logic [31:0] pos;
  logic        done;

  function automatic void clear_parser();
    walk = WALK_HEADER;
    fld_cnt = '0;
    shreg = '0;
    skip_left = '0;
    fmt_seen = 1'b0;
    fmt_tag = '0;
    fmt_len = '0;
    ch_cnt = '0;
    rate = '0;
    bits = '0;
    pos = '0;
    done = 1'b0;
  endfunction

  function automatic void open_chunk();
    walk = WALK_CHUNK;
    fld_cnt = '0;
    shreg = '0;
  endfunction

  function automatic void start_skip(logic [32:0] n);
    if (n == 0) begin
      open_chunk();
    end else begin
      skip_left = n;
      walk = WALK_SKIP;
    end
  endfunction

  function automatic void close_parse(logic [2:0] st, logic [31:0] off, logic [31:0] size);
    result_t r;
    r.status = st;
    r.channels = ch_cnt;
    r.sample_rate = rate;
    r.bits_per_sample = bits;
    r.pcm_start = off;
    r.pcm_bytes = size;
    header_reports_q.push_back(r);
    walk = WALK_DONE;
    done = 1'b1;
  endfunction

  function automatic void parse_word(logic [1:0] act, logic [7:0] b);
    logic [3:0]  idx;
    logic [31:0] id;
    logic [31:0] len;
    if (act == ACT_RESTART) begin
      clear_parser();
      return;
    end
    if (act == ACT_UNUSED || done) return;
    if (act == ACT_EOF) begin
      case (walk)
        WALK_HEADER: close_parse(ST_NOT_RIFF, '0, '0);
        WALK_FMT:    close_parse(ST_TRUNC, '0, '0);
        default:     close_parse(ST_NO_DATA, '0, '0);
      endcase
      return;
    end
    if (pos != POS_MAX) pos = pos + 1;
    idx = fld_cnt;
    fld_cnt = idx + 4'd1;
    case (walk)
      WALK_HEADER: begin
        if (idx < 4 || idx >= 8) shreg = {shreg[55:0], b};
        if (idx == 11) begin
          if (shreg != {ID_RIFF, ID_WAVE}) close_parse(ST_NOT_RIFF, '0, '0);
          else open_chunk();
        end
      end
      WALK_CHUNK: begin
        shreg = {shreg[55:0], b};
        if (idx == 7) begin
          id = shreg[63:32];
          len = {shreg[7:0], shreg[15:8], shreg[23:16], shreg[31:24]};
          if (id == ID_FMT) begin
            if (len < FMT_MIN_LEN) begin
              close_parse(ST_SHORT_FMT, '0, '0);
            end else begin
              fmt_len = len;
              walk = WALK_FMT;
              fld_cnt = '0;
              shreg = '0;
            end
          end else if (id == ID_DATA && fmt_seen) begin
            close_parse(ST_OK, pos, len);
          end else begin
            start_skip({1'b0, len} + len[0]);
          end
        end
      end
      WALK_FMT: begin
        if (idx == 0) fmt_tag = {8'h00, b};
        else if (idx == 1) fmt_tag[15:8] = b;
        else if (idx <= 7 || idx >= 14) shreg = {shreg[55:0], b};
        if (idx == 15) begin
          if (fmt_tag != PCM_TAG) begin
            close_parse(ST_NOT_PCM, '0, '0);
          end else begin
            ch_cnt = {shreg[55:48], shreg[63:56]};
            rate = {shreg[23:16], shreg[31:24], shreg[39:32], shreg[47:40]};
            bits = {shreg[7:0], shreg[15:8]};
            fmt_seen = 1'b1;
            start_skip({1'b0, fmt_len - FMT_MIN_LEN} + fmt_len[0]);
          end
        end
      end
      WALK_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 1;
        if (skip_left == 0) open_chunk();
      end
      default: ;
    endcase
  endfunction

  function automatic void put_word(logic [1:0] act, logic [7:0] b);
    word_t w;
    w.action = act;
    w.data = b;
    file_words_q.push_back(w);
    stim_words++;
  endfunction

  function automatic void add_be(logic [31:0] v);
    for (int k = 3; k >= 0; k--) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_random(int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_file();
    int          pick;
    int          cut;
    bit          huge;
    logic [31:0] len;
    file_bytes.delete();
    huge = 1'b0;
    add_be(ID_RIFF);
    add_le(pick32(), 4);
    add_be(ID_WAVE);
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, 11);
      file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
    end
    for (int i = $urandom_range(0, 4); i > 0; i--) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = ($urandom_range(0, 14) == 0) ? 32'($urandom_range(0, 15))
                                            : 32'($urandom_range(16, 21));
        add_be(ID_FMT);
        add_le(len, 4);
        if (len >= FMT_MIN_LEN) begin
          add_le(($urandom_range(0, 9) == 0) ? pick32() : 32'(PCM_TAG), 2);
          add_le(pick32(), 2);
          add_le(pick32(), 4);
          add_random(6);
          add_le(pick32(), 2);
          add_random(len - FMT_MIN_LEN + len[0]);
        end
      end else if (pick < 9) begin
        len = 32'($urandom_range(0, 9));
        add_be((pick < 7) ? 32'($urandom) : ID_DATA);
        add_le(len, 4);
        add_random(len + len[0]);
      end else begin
        add_be(ID_LIST);
        add_le($urandom | 32'h8000_0000, 4);
        huge = 1'b1;
        break;
      end
    end
    if (!huge && $urandom_range(0, 7) != 0) begin
      add_be(ID_DATA);
      add_le(pick32(), 4);
      add_random($urandom_range(0, 3));
    end
    cut = file_bytes.size();
    if ($urandom_range(0, 3) == 0) cut = $urandom_range(0, file_bytes.size());
    for (int i = 0; i < cut; i++) begin
      put_word(ACT_BYTE, file_bytes[i]);
      if ($urandom_range(0, 49) == 0) put_word(ACT_UNUSED, 8'($urandom));
    end
    if ($urandom_range(0, 9) != 0) put_word(ACT_EOF, 8'($urandom));
    put_word(ACT_RESTART, 8'($urandom));
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // driver
  int    burst_left;
  int    gap_left;
  word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= ACT_BYTE;
      data_byte_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_word(action_i, data_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (file_words_q.size() != 0) begin
          next_word = file_words_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= next_word.action;
          data_byte_i <= next_word.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int      stall_window;
  int      stall_mode;
  int      hold_cycles;
  int      holds_left = 3;
  result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_window = 0;
      stall_mode = 0;
      hold_cycles = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (header_reports_q.size() == 0) begin
          $error("unexpected result word: status %0d", status_o);
          mismatch_cnt++;
        end else begin
          want = header_reports_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            mismatch_cnt++;
          end
          if (channels_o !== want.channels) begin
            $error("channels: expected %0h, actual %0h", want.channels, channels_o);
            mismatch_cnt++;
          end
          if (sample_rate_o !== want.sample_rate) begin
            $error("sample_rate: expected %0h, actual %0h", want.sample_rate, sample_rate_o);
            mismatch_cnt++;
          end
          if (bits_per_sample_o !== want.bits_per_sample) begin
            $error("bits_per_sample: expected %0h, actual %0h", want.bits_per_sample,
                   bits_per_sample_o);
            mismatch_cnt++;
          end
          if (pcm_start_o !== want.pcm_start) begin
            $error("pcm_start: expected %0h, actual %0h", want.pcm_start, pcm_start_o);
            mismatch_cnt++;
          end
          if (pcm_bytes_o !== want.pcm_bytes) begin
            $error("pcm_bytes: expected %0h, actual %0h", want.pcm_bytes, pcm_bytes_o);
            mismatch_cnt++;
          end
        end
      end
      if (stall_window == 0) begin
        stall_window = $urandom_range(16, 128);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stall_window--;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (holds_left > 0 && out_valid_o &&
                   (holds_left == 3 || $urandom_range(0, 7) == 0)) begin
        holds_left--;
        hold_cycles = HOLD_LEN;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    clear_parser();
    put_word(ACT_UNUSED, 8'hff);
    put_word(ACT_EOF, 8'h00);
    put_word(ACT_BYTE, 8'h00);
    put_word(ACT_EOF, 8'hff);
    put_word(ACT_RESTART, 8'h00);
    file_bytes.delete();
    add_be(ID_RIFF);
    add_le('1, 4);
    add_be(ID_WAVE ^ 32'h0000_0003);
    foreach (file_bytes[i]) put_word(ACT_BYTE, file_bytes[i]);
    put_word(ACT_RESTART, 8'hff);
    for (int files = 0; stim_words < MIN_WORDS || files < MIN_FILES; files++) build_file();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (file_words_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (header_reports_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
